// ===== rtl/core/tcce_pkg.sv =====
// Package for the text console cursor engine.
// Holds request codes, character constants and the transaction payload types.
// Depends on nothing; every other file of the block imports it.
package tcce_pkg;

    localparam int unsigned ATTR_W    = 8;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned OUT_COL_W = 7;
    localparam int unsigned OUT_ROW_W = 5;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7E;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam int unsigned       TAB_STEP   = 4;
    localparam int unsigned       TAB_MASK   = 3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic [7:0]        target_col;
        logic [7:0]        target_row;
    } req_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] cursor_col;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [CELL_W-1:0]    cell_data;
        logic                 scrolled;
    } rsp_t;

    typedef struct packed {
        logic write_cell;
        logic blank;
        logic scroll;
    } put_flags_t;

endpackage

// ===== rtl/core/tcce_cursor_step.sv =====
// Cursor update for one put character request of the text console engine.
// Decodes the character, gives the new cursor, the cell to write and the scroll flag.
// Depends on tcce_pkg.
module tcce_cursor_step #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25,
    parameter int unsigned COL_W   = 7,
    parameter int unsigned ROW_W   = 5
) (
    input  logic [COL_W-1:0]           cur_col,
    input  logic [ROW_W-1:0]           cur_row,
    input  logic [tcce_pkg::CHAR_W-1:0] char_code,
    output logic [COL_W-1:0]           new_col,
    output logic [ROW_W-1:0]           new_row,
    output logic [COL_W-1:0]           write_col,
    output tcce_pkg::put_flags_t       flags
);
    import tcce_pkg::*;

    logic [COL_W+1:0] col_t;
    logic [ROW_W:0]   row_t;

    always_comb
    begin
        col_t     = {2'b00, cur_col};
        row_t     = {1'b0, cur_row};
        write_col = cur_col;
        flags     = '0;
        unique case (char_code)
            CHAR_LF:
            begin
                col_t = '0;
                row_t = row_t + 1'b1;
            end
            CHAR_CR:
            begin
                col_t = '0;
            end
            CHAR_TAB:
            begin
                col_t = (col_t + (COL_W+2)'(TAB_STEP)) & ~(COL_W+2)'(TAB_MASK);
            end
            CHAR_BS:
            begin
                if (cur_col != '0)
                begin
                    col_t            = col_t - 1'b1;
                    write_col        = cur_col - 1'b1;
                    flags.write_cell = 1'b1;
                    flags.blank      = 1'b1;
                end
            end
            default:
            begin
                if (char_code >= CHAR_BLANK && char_code <= CHAR_LAST)
                begin
                    flags.write_cell = 1'b1;
                    col_t            = col_t + 1'b1;
                end
            end
        endcase
        if (col_t >= (COL_W+2)'(COLUMNS))
        begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
        if (row_t >= (ROW_W+1)'(ROWS))
        begin
            flags.scroll = 1'b1;
            row_t        = (ROW_W+1)'(ROWS - 1);
            col_t        = '0;
        end
        new_col = col_t[COL_W-1:0];
        new_row = row_t[ROW_W-1:0];
    end

endmodule

// ===== rtl/core/text_console_cursor_engine.sv =====
// Text console cursor engine top level: screen store, cursor and request sequencer.
// Depends on tcce_pkg and tcce_cursor_step.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and each one gives
// exactly one response transaction on the rsp channel (rsp_valid, rsp_stall, rsp).
// A transaction moves when valid is high and stall is low. The attribute register
// is written on the cfg channel (cfg_valid, cfg_ready, cfg_data); cfg_ready is
// always high and writes are expected only while the engine is idle.
// Put character, set cursor and read cell pass through an execute state, in which
// put character and read cell use the shared cell address unit and the store, and
// a done state that loads the response register; only then does the sequencer return
// to idle to take the next request. A put character that scrolls then moves each of the
// (ROWS - 1) * COLUMNS lower cells up a row using both store ports, a read state and
// a write state per moved cell, and blanks the bottom row. Clear blanks every cell.
// After reset the store is filled with blanks in attribute 7, one cell a cycle;
// req_stall is high during that pass.
// A new request is taken while a response still waits in the output register;
// when the receiver stalls, the next response waits in the sequencer.
module text_console_cursor_engine #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  tcce_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output tcce_pkg::rsp_t                 rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0]    cfg_data
);
    import tcce_pkg::*;

    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned CELLS  = COLUMNS * ROWS;
    localparam int unsigned ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_MOVED  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_FILL   = 8'b0000_1000,
        S_SCR_RD = 8'b0001_0000,
        S_SCR_WR = 8'b0010_0000,
        S_BLANK  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ATTR_W-1:0]     attr_reg, attr_next;
    logic                  hit_reg, hit_next;
    logic                  scroll_reg, scroll_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    req_t                  req_reg;
    rsp_t                  rsp_reg, rsp_next;
    logic                  req_load;
    logic                  rsp_load;

    logic [CELL_W-1:0]     mem [CELLS];
    logic [CELL_W-1:0]     rdata_reg;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [CELL_W-1:0]     wr_data;

    logic [ROW_W-1:0]      addr_row;
    logic [COL_W-1:0]      addr_col;
    logic [ADDR_W-1:0]     cell_addr;

    logic [COL_W-1:0]      step_col, step_row_col;
    logic [ROW_W-1:0]      step_row;
    put_flags_t            step_flags;

    logic                  target_ok;
    logic [COL_W+OUT_COL_W-1:0] col_ext;
    logic [ROW_W+OUT_ROW_W-1:0] row_ext;

    tcce_cursor_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_step (
        .cur_col   (col_reg),
        .cur_row   (row_reg),
        .char_code (req_reg.char_code),
        .new_col   (step_col),
        .new_row   (step_row),
        .write_col (step_row_col),
        .flags     (step_flags)
    );

    assign target_ok = (req_reg.target_col < 8'(COLUMNS)) && (req_reg.target_row < 8'(ROWS));
    assign cell_addr = ADDR_W'(ADDR_W'(addr_row) * ROW_STRIDE) + ADDR_W'(addr_col);

    assign col_ext = {{OUT_COL_W{1'b0}}, col_reg};
    assign row_ext = {{OUT_ROW_W{1'b0}}, row_reg};

    assign req_stall = (state_reg != S_IDLE);
    assign req_load  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        hit_next       = hit_reg;
        scroll_next    = scroll_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rsp_load       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_addr        = ptr_reg;
        rd_addr        = ptr_reg + ROW_STRIDE;
        wr_data        = {attr_reg, CHAR_BLANK};
        addr_row       = row_reg;
        addr_col       = step_row_col;
        attr_next      = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we  = 1'b1;
                wr_data = {RESET_ATTR, CHAR_BLANK};
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_load)
                begin
                    hit_next    = 1'b0;
                    scroll_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (req_reg.req_type)
                    REQ_PUT:
                    begin
                        if (step_flags.write_cell)
                        begin
                            mem_we  = 1'b1;
                            wr_addr = cell_addr;
                            wr_data = {attr_reg,
                                       step_flags.blank ? CHAR_BLANK : req_reg.char_code};
                        end
                        col_next    = step_col;
                        row_next    = step_row;
                        scroll_next = step_flags.scroll;
                        if (step_flags.scroll)
                        begin
                            ptr_next   = '0;
                            state_next = S_SCR_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        ptr_next   = '0;
                        state_next = S_FILL;
                    end
                    REQ_SET:
                    begin
                        if (target_ok)
                        begin
                            col_next = req_reg.target_col[COL_W-1:0];
                            row_next = req_reg.target_row[ROW_W-1:0];
                        end
                        state_next = S_DONE;
                    end
                    REQ_READ:
                    begin
                        addr_row = req_reg.target_row[ROW_W-1:0];
                        addr_col = req_reg.target_col[COL_W-1:0];
                        rd_addr  = cell_addr;
                        mem_re   = target_ok;
                        hit_next = target_ok;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FILL:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCR_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                mem_we   = 1'b1;
                wr_data  = rdata_reg;
                ptr_next = ptr_reg + 1'b1;
                state_next = (ptr_reg == LAST_MOVED) ? S_BLANK : S_SCR_RD;
            end
            S_BLANK:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load            = 1'b1;
                    rsp_valid_next      = 1'b1;
                    rsp_next.cursor_col = col_ext[OUT_COL_W-1:0];
                    rsp_next.cursor_row = row_ext[OUT_ROW_W-1:0];
                    rsp_next.cell_data  = hit_reg ? rdata_reg : '0;
                    rsp_next.scrolled   = scroll_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= RESET_ATTR;
            hit_reg       <= 1'b0;
            scroll_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            hit_reg       <= hit_next;
            scroll_reg    <= scroll_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/tcce_console_checker.sv =====
// Response checker for the text console cursor engine testbench.
// Watches the request, response and attribute channels, keeps its own screen and cursor,
// and compares each response transaction with the predicted one. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_console_checker #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  tcce_pkg::req_t              req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  tcce_pkg::rsp_t              rsp,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0] cfg_data,
    output int                          mismatches,
    output int                          reports_due,
    output int                          reports_checked,
    output int                          scrolls_seen
);

    import tcce_pkg::*;

    localparam int unsigned CELLS = ROWS * COLUMNS;

    logic [CELL_W-1:0] screen [CELLS];
    logic [ATTR_W-1:0] attribute;
    int unsigned       col_now;
    int unsigned       row_now;
    rsp_t              cursor_reports [$];

    task automatic blank_screen();
        int i;
        for (i = 0; i < CELLS; i++) begin
            screen[i] = {attribute, CHAR_BLANK};
        end
    endtask

    task automatic console_step(input req_t item, output rsp_t report);
        int          i;
        logic [7:0]  ch;
        int unsigned tcol;
        int unsigned trow;
        ch              = item.char_code;
        tcol            = 32'(item.target_col);
        trow            = 32'(item.target_row);
        report          = '0;
        case (item.req_type)
            REQ_PUT:
            begin
                if (ch == CHAR_LF) begin
                    col_now = 0;
                    row_now++;
                end else if (ch == CHAR_CR) begin
                    col_now = 0;
                end else if (ch == CHAR_TAB) begin
                    col_now = (col_now + TAB_STEP) & ~TAB_MASK;
                end else if (ch == CHAR_BS) begin
                    if (col_now > 0) begin
                        col_now--;
                        screen[row_now * COLUMNS + col_now] = {attribute, CHAR_BLANK};
                    end
                end else if (ch >= CHAR_BLANK && ch <= CHAR_LAST) begin
                    screen[row_now * COLUMNS + col_now] = {attribute, ch};
                    col_now++;
                end
                if (col_now >= COLUMNS) begin
                    col_now = 0;
                    row_now++;
                end
                if (row_now >= ROWS) begin
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        screen[i] = screen[i + COLUMNS];
                    end
                    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                        screen[i] = {attribute, CHAR_BLANK};
                    end
                    row_now         = ROWS - 1;
                    col_now         = 0;
                    report.scrolled = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                blank_screen();
                col_now = 0;
                row_now = 0;
            end
            REQ_SET:
            begin
                if (tcol < COLUMNS && trow < ROWS) begin
                    col_now = tcol;
                    row_now = trow;
                end
            end
            default:
            begin
                if (tcol < COLUMNS && trow < ROWS) begin
                    report.cell_data = screen[trow * COLUMNS + tcol];
                end
            end
        endcase
        report.cursor_col = col_now[OUT_COL_W-1:0];
        report.cursor_row = row_now[OUT_ROW_W-1:0];
    endtask

    always @(posedge clk) begin
        rsp_t predicted;
        rsp_t wanted;
        if (!rst_n) begin
            attribute = RESET_ATTR;
            blank_screen();
            col_now = 0;
            row_now = 0;
            cursor_reports.delete();
            mismatches      <= 0;
            reports_checked <= 0;
            scrolls_seen    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                attribute = cfg_data;
            end
            if (req_valid && !req_stall) begin
                console_step(req, predicted);
                cursor_reports.push_back(predicted);
            end
            if (rsp_valid && !rsp_stall) begin
                reports_checked <= reports_checked + 1;
                if (cursor_reports.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: response with no request outstanding:", $time);
                        $display("%0t:     col %0d row %0d cell %h scrolled %0b",
                                 $time, rsp.cursor_col, rsp.cursor_row, rsp.cell_data,
                                 rsp.scrolled);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    wanted = cursor_reports.pop_front();
                    if (wanted.scrolled) begin
                        scrolls_seen <= scrolls_seen + 1;
                    end
                    if (rsp.cursor_col !== wanted.cursor_col
                            || rsp.cursor_row !== wanted.cursor_row
                            || rsp.cell_data !== wanted.cell_data
                            || rsp.scrolled !== wanted.scrolled) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch: expected col %0d row %0d cell %h scrolled %0b",
                                     $time, wanted.cursor_col, wanted.cursor_row,
                                     wanted.cell_data, wanted.scrolled);
                            $display("%0t:           got      col %0d row %0d cell %h scrolled %0b",
                                     $time, rsp.cursor_col, rsp.cursor_row, rsp.cell_data,
                                     rsp.scrolled);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        reports_due <= cursor_reports.size();
    end

endmodule

// ===== tb/tb_text_console_cursor_engine.sv =====
// Testbench top for the text console cursor engine.
// Drives directed and random console requests and attribute writes, applies random
// response stalls, and reports the verdict from tcce_console_checker. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;

    import tcce_pkg::*;

    localparam int unsigned COLUMNS    = 80;
    localparam int unsigned ROWS       = 25;
    localparam int          PHASES     = 7;
    localparam int          PHASE_REQS = 200;
    localparam int          REQ_W      = $bits(req_t);

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_stall;
    req_t                req_payload = '0;
    logic                rsp_valid;
    logic                rsp_stall  = 1'b0;
    rsp_t                rsp_payload;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   cfg_data   = '0;
    logic                steady     = 1'b0;
    int                  stall_left = 0;
    int                  mismatches;
    int                  reports_due;
    int                  reports_checked;
    int                  scrolls_seen;
    int                  attribute_writes = 0;

    always #5 clk = ~clk;

    text_console_cursor_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_payload),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tcce_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req_payload),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp_payload),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .reports_due     (reports_due),
        .reports_checked (reports_checked),
        .scrolls_seen    (scrolls_seen)
    );

    // The receiver stalls each response transaction at random, or not at all while steady.
    always @(posedge clk) begin
        int hold;
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end else if (rsp_valid && !rsp_stall) begin
            hold = steady ? 0 : $urandom_range(3, 0);
            stall_left <= hold;
            rsp_stall  <= (hold != 0);
        end else if (rsp_valid && stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
        end
    end

    function automatic req_t console_request(input logic [1:0] kind, input logic [7:0] ch,
                                             input logic [7:0] col, input logic [7:0] row);
        req_t item;
        item.req_type   = kind;
        item.char_code  = ch;
        item.target_col = col;
        item.target_row = row;
        return item;
    endfunction

    function automatic req_t random_console_request();
        req_t item;
        int   pick;
        int   sub;
        item = REQ_W'($urandom);
        pick = $urandom_range(99, 0);
        sub  = $urandom_range(9, 0);
        if (pick < 2) begin
            item.req_type = REQ_CLEAR;
        end else if (pick < 16) begin
            item.req_type = REQ_SET;
            if (sub < 4) begin
                item.target_col = 8'($urandom_range(COLUMNS - 1, 0));
                item.target_row = 8'($urandom_range(ROWS - 1, 0));
            end else if (sub < 7) begin
                item.target_col = 8'($urandom_range(COLUMNS - 1, COLUMNS - 20));
                item.target_row = 8'(ROWS - 1);
            end
        end else if (pick < 34) begin
            item.req_type = REQ_READ;
            if (sub < 7) begin
                item.target_col = 8'($urandom_range(COLUMNS - 1, 0));
                item.target_row = 8'($urandom_range(ROWS - 1, 0));
            end
        end else begin
            item.req_type = REQ_PUT;
            sub = $urandom_range(99, 0);
            if (sub < 5) begin
                item.char_code = CHAR_LF;
            end else if (sub < 9) begin
                item.char_code = CHAR_TAB;
            end else if (sub < 13) begin
                item.char_code = CHAR_BS;
            end else if (sub < 15) begin
                item.char_code = CHAR_CR;
            end else if (sub >= 23) begin
                item.char_code = 8'($urandom_range(CHAR_LAST, CHAR_BLANK));
            end
        end
        return item;
    endfunction

    task automatic send_request(input req_t item);
        int gap;
        gap = steady ? 0 : $urandom_range(3, 0);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_payload <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_all_reported();
        req_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attribute_writes++;
    endtask

    initial begin
        logic [ATTR_W-1:0] attr_plan [PHASES];
        int                phase;
        int                n;
        attr_plan[0] = 8'hFF;
        attr_plan[1] = 8'h00;
        for (phase = 2; phase < PHASES; phase++) begin
            attr_plan[phase] = 8'($urandom_range(255, 0));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests run in the reset attribute.
        send_request(console_request(REQ_READ, 8'h00, 8'd0, 8'd0));
        send_request(console_request(REQ_READ, 8'hFF, 8'(COLUMNS - 1), 8'(ROWS - 1)));
        send_request(console_request(REQ_READ, 8'h00, 8'(COLUMNS), 8'd0));
        send_request(console_request(REQ_READ, 8'h00, 8'd0, 8'(ROWS)));
        send_request(console_request(REQ_READ, 8'h00, 8'hFF, 8'hFF));
        send_request(console_request(REQ_PUT, 8'h41, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_LAST, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_BLANK, 8'hFF, 8'hFF));
        send_request(console_request(REQ_PUT, 8'h7F, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, 8'hFF, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, 8'h00, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_TAB, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_BS, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_LF, 8'h00, 8'h00));
        send_request(console_request(REQ_PUT, CHAR_CR, 8'h00, 8'h00));
        send_request(console_request(REQ_SET, 8'h00, 8'd0, 8'd0));
        send_request(console_request(REQ_PUT, CHAR_BS, 8'h00, 8'h00));
        send_request(console_request(REQ_SET, 8'h00, 8'(COLUMNS), 8'd3));
        send_request(console_request(REQ_SET, 8'h00, 8'd5, 8'(ROWS)));
        send_request(console_request(REQ_SET, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1)));
        send_request(console_request(REQ_PUT, 8'h5A, 8'h00, 8'h00));
        send_request(console_request(REQ_SET, 8'h00, 8'(COLUMNS - 2), 8'(ROWS - 1)));
        send_request(console_request(REQ_PUT, CHAR_TAB, 8'h00, 8'h00));
        send_request(console_request(REQ_READ, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 3)));
        send_request(console_request(REQ_CLEAR, 8'h00, 8'h00, 8'h00));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_all_reported();
            write_attribute(attr_plan[phase]);
            if (phase == 0) begin
                send_request(console_request(REQ_SET, 8'h00, 8'd10, 8'(ROWS - 1)));
                send_request(console_request(REQ_PUT, CHAR_LF, 8'h00, 8'h00));
                send_request(console_request(REQ_READ, 8'h00, 8'd0, 8'(ROWS - 1)));
            end
            for (n = 0; n < PHASE_REQS; n++) begin
                if (n == 60) begin
                    steady <= 1'b1;
                end else if (n == 100) begin
                    steady <= 1'b0;
                end
                send_request(random_console_request());
            end
        end

        wait_all_reported();
        repeat (50) @(posedge clk);
        $display("Covered %0d console requests, %0d of them scrolling,",
                 reports_checked, scrolls_seen);
        $display("over %0d attribute settings.", attribute_writes + 1);
        if (mismatches == 0 && reports_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
